@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms for the calendar converter
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock, off while in reset
`define ULC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition in one cycle forces a condition in the next
`define ULC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/ulc_pkg.sv @@
// ----------------------------------------------------------------------------
// ulc_pkg
// types, constants and small tables of the utc to local calendar converter
// ----------------------------------------------------------------------------
package ulc_pkg;

  localparam int unsigned NStages = 11;

  // time of day
  localparam logic [16:0] SecMax      = 17'd86399;
  localparam logic [18:0] SecsPerDay  = 19'd86400;
  localparam logic [16:0] SecsPerHour = 17'd3600;
  localparam logic [11:0] SecsPerMin  = 12'd60;
  // floor(x / 225) = (x * Recip225) >> 20 for x < 5400
  localparam logic [12:0] Recip225    = 13'd4661;
  // floor(x / 15) = (x * Recip15) >> 16 for x < 900
  localparam logic [12:0] Recip15     = 13'd4370;

  // calendar, day count shifted to start at 0000-03-01
  localparam int          DaysPerEra  = 146097;
  localparam logic [19:0] ZEpoch      = 20'd730425;  // 10957 + 719468
  localparam logic [19:0] Era4Start   = 20'(4 * DaysPerEra);
  localparam logic [19:0] Era5Start   = 20'(5 * DaysPerEra);
  localparam logic [11:0] Era4Year    = 12'd1600;
  localparam logic [11:0] Era5Year    = 12'd2000;
  // floor(x / 365) = (x * Recip365) >> 24 for x < 146097
  localparam logic [15:0] Recip365    = 16'd45965;
  // floor(x / 153) = (x * Recip153) >> 20 for x < 2048
  localparam logic [12:0] Recip153    = 13'd6854;
  // floor(x / 7) = (x * Recip7) >> 15 for x < 4096
  localparam logic [12:0] Recip7      = 13'd4682;

  typedef logic [NStages-1:0] stage_en_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [2:0]  weekday;
  } date_t;

  // first day of year of each month of a march-based year
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // weekday offset per calendar month
  function automatic logic [2:0] week_offset(input logic [3:0] month);
    logic [2:0] r;
    case (month)
      4'd1:    r = 3'd0;
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd2;
      4'd4:    r = 3'd5;
      4'd5:    r = 3'd0;
      4'd6:    r = 3'd3;
      4'd7:    r = 3'd5;
      4'd8:    r = 3'd1;
      4'd9:    r = 3'd4;
      4'd10:   r = 3'd6;
      4'd11:   r = 3'd2;
      4'd12:   r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/ulc_wrap.sv @@
// ----------------------------------------------------------------------------
// ulc_wrap
// adds the utc offset and wraps into one local day, stages one and two
// ----------------------------------------------------------------------------
module ulc_wrap import ulc_pkg::*; (
  input  logic        clk_i,
  input  logic [1:0]  en_i,
  input  logic [16:0] utc_seconds_i,
  input  logic [15:0] days_i,
  input  logic [10:0] offset_i,
  output logic [16:0] ls_o,
  output logic [19:0] z_o
);

  logic [16:0]        secs_sat;
  logic signed [18:0] off_ext;
  logic signed [18:0] off60;
  logic signed [18:0] local_s;
  logic [18:0]        local_d, local_q;
  logic [15:0]        days_q;

  logic               neg, over;
  logic [18:0]        sum_add, sum_sub;
  logic [16:0]        ls_d, ls_q;
  logic [19:0]        z_d, z_q;

  // stage 1: saturate and add offset * 60
  always_comb begin
    secs_sat = (utc_seconds_i > SecMax) ? SecMax : utc_seconds_i;
    off_ext  = $signed({{8{offset_i[10]}}, offset_i});
    off60    = (off_ext <<< 6) - (off_ext <<< 2);
    local_s  = $signed({2'b00, secs_sat}) + off60;
    local_d  = local_s;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      local_q <= local_d;
      days_q  <= days_i;
    end
  end

  // stage 2: one wrap either way
  always_comb begin
    neg     = local_q[18];
    over    = !neg && (local_q >= SecsPerDay);
    sum_add = local_q + SecsPerDay;
    sum_sub = local_q - SecsPerDay;
    if (neg) begin
      ls_d = sum_add[16:0];
      z_d  = {4'b0000, days_q} + ZEpoch - 20'd1;
    end else if (over) begin
      ls_d = sum_sub[16:0];
      z_d  = {4'b0000, days_q} + ZEpoch + 20'd1;
    end else begin
      ls_d = local_q[16:0];
      z_d  = {4'b0000, days_q} + ZEpoch;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      ls_q <= ls_d;
      z_q  <= z_d;
    end
  end

  assign ls_o = ls_q;
  assign z_o  = z_q;

endmodule

@@ hdl/ulc_hms.sv @@
// ----------------------------------------------------------------------------
// ulc_hms
// splits local seconds of day into hour, minute and second
// ----------------------------------------------------------------------------
module ulc_hms import ulc_pkg::*; (
  input  logic        clk_i,
  input  stage_en_t   en_i,
  input  logic [16:0] ls_i,
  output hms_t        hms_o
);

  logic [25:0] p3;
  logic [4:0]  hour3_q, hour4_q, hour5_q;
  logic [16:0] ls3_q;
  logic [16:0] hsec4, diff4;
  logic [11:0] rem4_q, rem5_q;
  logic [22:0] p5;
  logic [5:0]  min5_q;
  logic [11:0] sdiff6;
  hms_t        pipe_q [5:NStages-1];

  assign p3     = 26'(ls_i[16:4]) * 26'(Recip225);
  assign hsec4  = 17'(hour3_q) * SecsPerHour;
  assign diff4  = ls3_q - hsec4;
  assign p5     = 23'(rem4_q[11:2]) * 23'(Recip15);
  assign sdiff6 = rem5_q - 12'(min5_q) * SecsPerMin;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      hour3_q <= p3[24:20];
      ls3_q   <= ls_i;
    end
    if (en_i[3]) begin
      hour4_q <= hour3_q;
      rem4_q  <= diff4[11:0];
    end
    if (en_i[4]) begin
      hour5_q <= hour4_q;
      rem5_q  <= rem4_q;
      min5_q  <= p5[21:16];
    end
    if (en_i[5]) begin
      pipe_q[5] <= '{hour: hour5_q, minute: min5_q, second: sdiff6[5:0]};
    end
    // delay line to line up with the date path
    for (int k = 6; k < NStages; k++) begin
      if (en_i[k]) begin
        pipe_q[k] <= pipe_q[k-1];
      end
    end
  end

  assign hms_o = pipe_q[NStages-1];

endmodule

@@ hdl/ulc_civil.sv @@
// ----------------------------------------------------------------------------
// ulc_civil
// civil-from-days date conversion and weekday, stages three to eleven
// ----------------------------------------------------------------------------
module ulc_civil import ulc_pkg::*; (
  input  logic        clk_i,
  input  stage_en_t   en_i,
  input  logic [19:0] z_i,
  output date_t       date_o
);

  // stage 3
  logic        era3;
  logic [19:0] doe_full;
  logic        era3_q;
  logic [17:0] doe3_q;
  // stage 4
  logic [31:0] p4;
  logic [2:0]  q36524;
  logic        era4_q;
  logic [17:0] doe4_q;
  logic [6:0]  q1460_q;
  logic [2:0]  q36524_q;
  logic        q146096_q;
  // stage 5
  logic        era5_q;
  logic [17:0] doe5_q, t5_q;
  // stage 6
  logic [33:0] p6;
  logic        era6_q;
  logic [17:0] doe6_q;
  logic [8:0]  yoe6_q;
  // stage 7
  logic [1:0]  yc;
  logic [17:0] base7, doy7;
  logic        era7_q;
  logic [8:0]  yoe7_q, doy7_q;
  logic [1:0]  yc7_q;
  // stage 8
  logic [10:0] v8;
  logic [23:0] p8;
  logic        era8_q;
  logic [8:0]  yoe8_q, doy8_q;
  logic [1:0]  yc8_q;
  logic [3:0]  mp8_q;
  // stage 9
  logic [11:0] yy9, wsum9;
  logic [8:0]  day9;
  logic [3:0]  month9;
  logic [4:0]  day9_q;
  logic [3:0]  month9_q;
  logic [11:0] year9_q, wsum9_q;
  // stage 10
  logic [4:0]  day10_q;
  logic [3:0]  month10_q;
  logic [11:0] year10_q, n10_q;
  // stage 11
  logic [24:0] p11;
  logic [11:0] rem11;
  date_t       date_q;

  always_comb begin
    era3     = (z_i >= Era5Start);
    doe_full = era3 ? (z_i - Era5Start) : (z_i - Era4Start);
    p4       = 32'(doe3_q[17:2]) * 32'(Recip365);
    q36524   = {2'b00, doe3_q >= 18'd36524} + {2'b00, doe3_q >= 18'd73048}
             + {2'b00, doe3_q >= 18'd109572} + {2'b00, doe3_q >= 18'd146096};
    p6       = 34'(t5_q) * 34'(Recip365);
    yc       = {1'b0, yoe6_q >= 9'd100} + {1'b0, yoe6_q >= 9'd200}
             + {1'b0, yoe6_q >= 9'd300};
    base7    = 18'(yoe6_q) * 18'd365 + 18'(yoe6_q[8:2]) - 18'(yc);
    doy7     = doe6_q - base7;
    v8       = 11'(doy7_q) * 11'd5 + 11'd2;
    p8       = 24'(v8) * 24'(Recip153);
    yy9      = 12'(yoe8_q) + (era8_q ? Era5Year : Era4Year);
    day9     = doy8_q - month_start(mp8_q) + 9'd1;
    month9   = (mp8_q < 4'd10) ? (mp8_q + 4'd3) : (mp8_q - 4'd9);
    // yy + yy/4 - yy/100 + yy/400, with yy/100 = 4*era + yoe/100 and yy/400 = era
    wsum9    = yy9 + {2'b00, yy9[11:2]} - {10'b0, yc8_q}
             - (era8_q ? 12'd15 : 12'd12);
    p11      = 25'(n10_q) * 25'(Recip7);
    rem11    = n10_q - 12'(p11[23:15]) * 12'd7;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      era3_q <= era3;
      doe3_q <= doe_full[17:0];
    end
    if (en_i[3]) begin
      era4_q    <= era3_q;
      doe4_q    <= doe3_q;
      q1460_q   <= p4[30:24];
      q36524_q  <= q36524;
      q146096_q <= (doe3_q >= 18'd146096);
    end
    if (en_i[4]) begin
      era5_q <= era4_q;
      doe5_q <= doe4_q;
      t5_q   <= doe4_q - 18'(q1460_q) + 18'(q36524_q) - 18'(q146096_q);
    end
    if (en_i[5]) begin
      era6_q <= era5_q;
      doe6_q <= doe5_q;
      yoe6_q <= p6[32:24];
    end
    if (en_i[6]) begin
      era7_q <= era6_q;
      yoe7_q <= yoe6_q;
      yc7_q  <= yc;
      doy7_q <= doy7[8:0];
    end
    if (en_i[7]) begin
      era8_q <= era7_q;
      yoe8_q <= yoe7_q;
      yc8_q  <= yc7_q;
      doy8_q <= doy7_q;
      mp8_q  <= p8[23:20];
    end
    if (en_i[8]) begin
      day9_q   <= day9[4:0];
      month9_q <= month9;
      // january and february of a march-based year fall in the next calendar year
      year9_q  <= yy9 + 12'(mp8_q >= 4'd10);
      wsum9_q  <= wsum9;
    end
    if (en_i[9]) begin
      day10_q   <= day9_q;
      month10_q <= month9_q;
      year10_q  <= year9_q;
      n10_q     <= wsum9_q + 12'(week_offset(month9_q)) + 12'(day9_q);
    end
    if (en_i[10]) begin
      date_q <= '{day: day10_q, month: month10_q, year: year10_q, weekday: rem11[2:0]};
    end
  end

  assign date_o = date_q;

endmodule

@@ hdl/utc_to_local_calendar.sv @@
// ----------------------------------------------------------------------------
// utc_to_local_calendar
// utc time of day and day count to local time, calendar date and weekday
// ----------------------------------------------------------------------------
// Takes one request per clock and passes it through the eleven-stage
// pipeline, whose depth is set by the chain of reciprocal multiplications
// of the date conversion. Full throughput holds as long as the output
// side does not stall; an output stall fills empty stages first, so
// in_stall_o rises only when all eleven stages hold requests. Seconds
// above 86399 read as 86399. The utc offset register may be written only
// while no request is in flight.
`include "assert_macros.svh"

module utc_to_local_calendar import ulc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [16:0] utc_seconds_i,
  input  logic [15:0] days_since_2000_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_o,
  output logic [11:0] year_o,
  output logic [2:0]  weekday_o
);

  logic [10:0] offset_q;
  stage_en_t   valid_d, valid_q;
  stage_en_t   ready;
  logic [16:0] ls;
  logic [19:0] z;
  hms_t        hms;
  date_t       date;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (cfg_we_i) begin
      offset_q <= cfg_data_i;
    end
  end

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    ready[NStages-1] = !valid_q[NStages-1] || !out_stall_i;
    for (int k = NStages - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
    valid_d[0] = ready[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NStages; k++) begin
      valid_d[k] = ready[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[NStages-1];

  ulc_wrap u_wrap (
    .clk_i         (clk_i),
    .en_i          (ready[1:0]),
    .utc_seconds_i (utc_seconds_i),
    .days_i        (days_since_2000_i),
    .offset_i      (offset_q),
    .ls_o          (ls),
    .z_o           (z)
  );

  ulc_hms u_hms (
    .clk_i (clk_i),
    .en_i  (ready),
    .ls_i  (ls),
    .hms_o (hms)
  );

  ulc_civil u_civil (
    .clk_i  (clk_i),
    .en_i   (ready),
    .z_i    (z),
    .date_o (date)
  );

  assign hour_o         = hms.hour;
  assign minute_o       = hms.minute;
  assign second_o       = hms.second;
  assign day_of_month_o = date.day;
  assign month_o        = date.month;
  assign year_o         = date.year;
  assign weekday_o      = date.weekday;

  `ULC_ASSERT(a_stall_only_full, in_stall_o |-> (&valid_q), "input stalled with a free stage")
  `ULC_ASSERT_NEXT(a_last_moves, valid_q[NStages-2] && !out_stall_i, out_valid_o, "request lost before output")
  `ULC_ASSERT(a_time_range, out_valid_o |-> (hour_o < 5'd24 && minute_o < 6'd60 && second_o < 6'd60), "local time out of range")
  `ULC_ASSERT(a_date_range, out_valid_o |-> (month_o != 4'd0 && month_o <= 4'd12 && day_of_month_o != 5'd0 && weekday_o != 3'd7), "date out of range")

endmodule
